// ===== src/wsd_pkg.sv =====
// wsd_pkg: shared types and constants for the websocket frame deframer
// used by the parser, the result queue, the top level and the checker
`default_nettype none

package wsd_pkg;

    // default width of the frame length counter
    localparam int LENGTH_BITS_DEF = 64;

    // result queue depth (two results may be pushed per beat)
    localparam int OQ_DEPTH = 4;

    // parse phases
    localparam logic [2:0] PH_HDR0 = 3'd0;
    localparam logic [2:0] PH_HDR1 = 3'd1;
    localparam logic [2:0] PH_EXT  = 3'd2;
    localparam logic [2:0] PH_KEY  = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_HALT = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_PONG    = 2'd1;
    localparam logic [1:0] KIND_EVENT   = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_CLOSE     = 3'd1;
    localparam logic [2:0] ST_BAD_START = 3'd2;
    localparam logic [2:0] ST_BAD_CONT  = 3'd3;
    localparam logic [2:0] ST_BAD_CTRL  = 3'd4;

    // opcodes
    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    // header constants
    localparam logic [6:0] LEN_EXT16   = 7'd126;
    localparam logic [6:0] LEN_EXT64   = 7'd127;
    localparam logic [6:0] LEN_CTRL_MAX = 7'd125;
    localparam logic [7:0] PONG_HDR    = 8'h8A;
    localparam logic [3:0] CNT_EXT16   = 4'd2;
    localparam logic [3:0] CNT_EXT64   = 4'd8;
    localparam logic [3:0] CNT_KEY     = 4'd4;

    // one result beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] out_kind;
        logic       message_binary;
        logic       message_end;
        logic [2:0] status;
        logic       last;
    } result_t;

    // results caused by one input beat
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } parse_out_t;

endpackage

`default_nettype wire

// ===== src/wsd_parser.sv =====
// wsd_parser: frame header parser, unmasking and result generation
// depends on wsd_pkg; one input beat per cycle while beat_en is high, up to two results per beat
`default_nettype none

module wsd_parser
    import wsd_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       beat_en,
    input  wire logic [7:0] rx_byte,
    output parse_out_t      res
);

    logic [2:0]             phase_reg, phase_next;
    logic [3:0]             field_cnt_reg, field_cnt_next;
    logic [3:0]             opcode_reg, opcode_next;
    logic                   final_reg, final_next;
    logic                   masked_reg, masked_next;
    logic [LENGTH_BITS-1:0] rem_reg, rem_next;
    logic [31:0]            key_reg, key_next;
    logic [1:0]             midx_reg, midx_next;
    logic                   frag_reg, frag_next;
    logic                   bin_reg, bin_next;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HDR0;
            field_cnt_reg <= '0;
            opcode_reg    <= '0;
            final_reg     <= 1'b0;
            masked_reg    <= 1'b0;
            rem_reg       <= '0;
            key_reg       <= '0;
            midx_reg      <= '0;
            frag_reg      <= 1'b0;
            bin_reg       <= 1'b0;
        end
        else if (beat_en)
        begin
            phase_reg     <= phase_next;
            field_cnt_reg <= field_cnt_next;
            opcode_reg    <= opcode_next;
            final_reg     <= final_next;
            masked_reg    <= masked_next;
            rem_reg       <= rem_next;
            key_reg       <= key_next;
            midx_reg      <= midx_next;
            frag_reg      <= frag_next;
            bin_reg       <= bin_next;
        end
    end

    logic [3:0]             op_in;
    logic                   fin_in;
    logic [6:0]             len7;
    logic [3:0]             cnt_dec;
    logic                   hd_go;
    logic [LENGTH_BITS-1:0] hd_len;
    logic                   data_end;
    logic [7:0]             key_byte;
    logic [7:0]             data_byte;

    assign op_in   = rx_byte[3:0];
    assign fin_in  = rx_byte[7];
    assign len7    = rx_byte[6:0];
    assign cnt_dec = field_cnt_reg - 4'd1;

    // key byte chosen by the rolling index, most significant first
    always_comb
    begin
        unique case (midx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    assign data_byte = masked_reg ? (rx_byte ^ key_byte) : rx_byte;
    assign data_end  = (rem_reg == LENGTH_BITS'(1));

    // next state and results
    always_comb
    begin
        phase_next     = phase_reg;
        field_cnt_next = field_cnt_reg;
        opcode_next    = opcode_reg;
        final_next     = final_reg;
        masked_next    = masked_reg;
        rem_next       = rem_reg;
        key_next       = key_reg;
        midx_next      = midx_reg;
        frag_next      = frag_reg;
        bin_next       = bin_reg;
        hd_go          = 1'b0;
        hd_len         = rem_reg;
        res            = '0;

        unique case (phase_reg)
            PH_HDR0:
            begin
                opcode_next = op_in;
                final_next  = fin_in;
                phase_next  = PH_HDR1;
                if (op_in == OP_CLOSE)
                begin
                    res.count        = 2'd1;
                    res.r0.out_kind  = KIND_EVENT;
                    res.r0.status    = ST_CLOSE;
                    phase_next       = PH_HALT;
                end
                else if (op_in[3])
                begin
                    if (op_in > OP_PONG || !fin_in)
                    begin
                        res.count       = 2'd1;
                        res.r0.out_kind = KIND_EVENT;
                        res.r0.status   = ST_BAD_CTRL;
                        phase_next      = PH_HALT;
                    end
                end
                else if (frag_reg)
                begin
                    if (op_in != OP_CONT)
                    begin
                        res.count       = 2'd1;
                        res.r0.out_kind = KIND_EVENT;
                        res.r0.status   = ST_BAD_CONT;
                        phase_next      = PH_HALT;
                    end
                    else
                    begin
                        frag_next = !fin_in;
                    end
                end
                else
                begin
                    if (op_in != OP_TEXT && op_in != OP_BINARY)
                    begin
                        res.count       = 2'd1;
                        res.r0.out_kind = KIND_EVENT;
                        res.r0.status   = ST_BAD_START;
                        phase_next      = PH_HALT;
                    end
                    else
                    begin
                        bin_next  = (op_in == OP_BINARY);
                        frag_next = !fin_in;
                    end
                end
            end

            PH_HDR1:
            begin
                masked_next = rx_byte[7];
                if (opcode_reg[3] && len7 > LEN_CTRL_MAX)
                begin
                    res.count       = 2'd1;
                    res.r0.out_kind = KIND_EVENT;
                    res.r0.status   = ST_BAD_CTRL;
                    phase_next      = PH_HALT;
                end
                else if (len7 == LEN_EXT16 || len7 == LEN_EXT64)
                begin
                    rem_next       = '0;
                    field_cnt_next = (len7 == LEN_EXT16) ? CNT_EXT16 : CNT_EXT64;
                    phase_next     = PH_EXT;
                end
                else
                begin
                    rem_next = {{(LENGTH_BITS-7){1'b0}}, len7};
                    if (rx_byte[7])
                    begin
                        field_cnt_next = CNT_KEY;
                        phase_next     = PH_KEY;
                    end
                    else
                    begin
                        hd_go  = 1'b1;
                        hd_len = {{(LENGTH_BITS-7){1'b0}}, len7};
                    end
                end
            end

            PH_EXT:
            begin
                // saturate once the next shift would lose bits
                if (rem_reg[LENGTH_BITS-1 -: 8] != 8'd0)
                    rem_next = '1;
                else
                    rem_next = {rem_reg[LENGTH_BITS-9:0], rx_byte};
                field_cnt_next = cnt_dec;
                if (cnt_dec == 4'd0)
                begin
                    if (masked_reg)
                    begin
                        field_cnt_next = CNT_KEY;
                        phase_next     = PH_KEY;
                    end
                    else
                    begin
                        hd_go  = 1'b1;
                        hd_len = rem_next;
                    end
                end
            end

            PH_KEY:
            begin
                key_next       = {key_reg[23:0], rx_byte};
                field_cnt_next = cnt_dec;
                if (cnt_dec == 4'd0)
                begin
                    hd_go  = 1'b1;
                    hd_len = rem_reg;
                end
            end

            PH_DATA:
            begin
                midx_next = midx_reg + 2'd1;
                rem_next  = rem_reg - LENGTH_BITS'(1);
                if (!opcode_reg[3])
                begin
                    res.count             = 2'd1;
                    res.r0.out_byte       = data_byte;
                    res.r0.out_kind       = KIND_PAYLOAD;
                    res.r0.message_binary = bin_reg;
                    res.r0.message_end    = data_end && final_reg;
                end
                else if (opcode_reg == OP_PING)
                begin
                    res.count       = 2'd1;
                    res.r0.out_byte = data_byte;
                    res.r0.out_kind = KIND_PONG;
                end
                if (data_end)
                    phase_next = PH_HDR0;
            end

            PH_HALT:
            begin
                phase_next = PH_HALT;
            end

            default:
            begin
                phase_next = PH_HALT;
            end
        endcase

        // end of header: pong header echo, empty frame handling
        if (hd_go)
        begin
            midx_next = 2'd0;
            if (opcode_reg == OP_PING)
            begin
                res.count       = 2'd2;
                res.r0.out_byte = PONG_HDR;
                res.r0.out_kind = KIND_PONG;
                res.r1.out_byte = {1'b0, hd_len[6:0]};
                res.r1.out_kind = KIND_PONG;
            end
            if (hd_len == '0)
            begin
                if (!opcode_reg[3] && final_reg)
                begin
                    res.count             = 2'd1;
                    res.r0.out_kind       = KIND_EVENT;
                    res.r0.message_binary = bin_reg;
                    res.r0.message_end    = 1'b1;
                end
                phase_next = PH_HDR0;
            end
            else
            begin
                phase_next = PH_DATA;
            end
        end

        // mark the last result of this beat
        if (res.count == 2'd1)
            res.r0.last = 1'b1;
        else if (res.count == 2'd2)
            res.r1.last = 1'b1;
    end

endmodule

`default_nettype wire

// ===== src/wsd_outq.sv =====
// wsd_outq: small result queue, up to two pushes and one pop per cycle
// depends on wsd_pkg for result_t, parse_out_t and OQ_DEPTH
`default_nettype none

module wsd_outq
    import wsd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push_en,
    input  wire parse_out_t push,
    output logic            full,
    output logic            pop_valid,
    input  wire logic       pop_stall,
    output result_t         head
);

    localparam int PTR_W = $clog2(OQ_DEPTH);
    localparam int CNT_W = $clog2(OQ_DEPTH + 1);

    result_t            entry_reg [OQ_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [1:0]         push_n;
    logic               pop;

    assign push_n    = push_en ? push.count : 2'd0;
    assign pop_valid = (count_reg != '0);
    assign pop       = pop_valid && !pop_stall;
    assign head      = entry_reg[rd_ptr_reg];
    // room for two results is needed before a beat is taken
    assign full      = (count_reg > CNT_W'(OQ_DEPTH - 2));

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + (pop ? PTR_W'(1) : PTR_W'(0));
        count_next  = count_reg + CNT_W'(push_n) - (pop ? CNT_W'(1) : CNT_W'(0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            entry_reg[wr_ptr_reg] <= push.r0;
        if (push_n == 2'd2)
            entry_reg[wr_ptr_reg + PTR_W'(1)] <= push.r1;
    end

endmodule

`default_nettype wire

// ===== src/websocket_frame_deframer_unit.sv =====
// websocket_frame_deframer_unit: receive-side websocket frame deframer
// depends on wsd_pkg, wsd_parser and wsd_outq
//
// Usage
//   Input channel: one received byte per beat on rx_byte, in_valid/in_stall.
//   Output channel: one result per beat (out_byte, out_kind, message_binary,
//   message_end, status, last), out_valid/out_stall.
//   The parser updates its state on the same edge that takes the byte and
//   writes the results into a four-entry result queue, from which they
//   reach the output in order, behind any results still held there.
//   Throughput is one byte per cycle while each byte gives at most one result
//   and the receiver keeps up; the end of a ping header gives two results,
//   and the queue drains one result per cycle.
//   in_stall rises when the queue holds more than two results, so a stalled
//   receiver backs up the input; nothing is lost.
//   After reset the parser waits for the first header byte of a frame and
//   the queue is empty. After a close or a protocol error the parser halts
//   and takes bytes without results until the next reset.
`default_nettype none

module websocket_frame_deframer_unit
    import wsd_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic [1:0]      out_kind,
    output logic            message_binary,
    output logic            message_end,
    output logic [2:0]      status,
    output logic            last
);

    logic       beat_en;
    logic       q_full;
    parse_out_t parse_res;
    result_t    head;

    assign in_stall = q_full;
    assign beat_en  = in_valid && !q_full;

    // header parsing and unmasking
    wsd_parser #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .beat_en (beat_en),
        .rx_byte (rx_byte),
        .res     (parse_res)
    );

    // result queue between parser and receiver
    wsd_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (beat_en),
        .push      (parse_res),
        .full      (q_full),
        .pop_valid (out_valid),
        .pop_stall (out_stall),
        .head      (head)
    );

    assign out_byte       = head.out_byte;
    assign out_kind       = head.out_kind;
    assign message_binary = head.message_binary;
    assign message_end    = head.message_end;
    assign status         = head.status;
    assign last           = head.last;

endmodule

`default_nettype wire

// ===== src/wsd_check.sv =====
// wsd_check: port-level assertions for websocket_frame_deframer_unit
// depends on wsd_pkg; attached to the top level by the bind at the end
`default_nettype none

module wsd_check
    import wsd_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] out_byte,
    input wire logic [1:0] out_kind,
    input wire logic       message_binary,
    input wire logic       message_end,
    input wire logic [2:0] status,
    input wire logic       last
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_kind)
            && $stable(last))
        else $error("stalled result beat changed");

    // an error or close event is the only result of its byte
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> last && out_kind == KIND_EVENT)
        else $error("status event not alone");

    // pong bytes carry no message marks
    a_pong_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == KIND_PONG |-> !message_binary && !message_end
            && status == ST_OK)
        else $error("pong beat with message marks");

    // an event without status is an empty message end
    a_event_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == KIND_EVENT && status == ST_OK |-> message_end
            && out_byte == 8'd0)
        else $error("plain event without message end");

endmodule

bind websocket_frame_deframer_unit wsd_check u_wsd_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_kind       (out_kind),
    .message_binary (message_binary),
    .message_end    (message_end),
    .status         (status),
    .last           (last)
);

`default_nettype wire
